[hw/rtl/pcoc_pkg.sv]
// ----------------------------------------------------------------------------
// pcoc_pkg
// Shared types and constants for the phase current offset calibration block.
// ----------------------------------------------------------------------------
package pcoc_pkg;

  // Raw converter reading width and result widths.
  localparam int RAW_W = 16;
  localparam int CUR_W = 16;
  localparam int CURC_W = 17;

  // Calibration run length. The mean is a right shift, so the run is a power of two.
  localparam int NUM_SAMPLES_LOG2 = 4;
  localparam int NUM_SAMPLES = 1 << NUM_SAMPLES_LOG2;
  localparam int SUM_W = RAW_W + NUM_SAMPLES_LOG2;
  localparam int CNT_W = NUM_SAMPLES_LOG2 + 1;

  // Symmetric saturation limit of one phase difference.
  localparam int CUR_LIMIT = 32767;

  // Stream widths.
  localparam int MODE_W = 2;
  localparam int IN_DATA_W = 2 * RAW_W;
  localparam int OUT_FIELDS_W = 2 * CUR_W + CURC_W + 1;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Item kinds carried in the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_RESTART = 2'd0,
    MODE_CAL     = 2'd1,
    MODE_MEAS    = 2'd2
  } mode_t;

  // Calibration state seen by the rest of the block.
  typedef struct packed {
    logic [RAW_W-1:0] offset_a;
    logic [RAW_W-1:0] offset_b;
    logic             done;
    logic             done_next;
    logic [CNT_W-1:0] count;
  } calib_status_t;

  // One result word.
  typedef struct packed {
    logic signed [CURC_W-1:0] current_c;
    logic signed [CUR_W-1:0]  current_b;
    logic signed [CUR_W-1:0]  current_a;
  } currents_t;

endpackage

[hw/rtl/pcoc_calib.sv]
// ----------------------------------------------------------------------------
// pcoc_calib
// Offset accumulator: sums a run of calibration samples and stores the means.
// ----------------------------------------------------------------------------
module pcoc_calib (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  pcoc_pkg::mode_t            mode,
  input  logic [pcoc_pkg::RAW_W-1:0] raw_a,
  input  logic [pcoc_pkg::RAW_W-1:0] raw_b,
  output pcoc_pkg::calib_status_t    status
);
  import pcoc_pkg::*;

  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] count;
  logic [RAW_W-1:0] offset_a;
  logic [RAW_W-1:0] offset_b;
  logic             done;

  logic [SUM_W-1:0] sum_a_next;
  logic [SUM_W-1:0] sum_b_next;
  logic             full;
  logic             take;
  logic             last;

  // A sample is taken only while the run is not yet complete.
  assign full = (count == CNT_W'(NUM_SAMPLES));
  assign take = (mode == MODE_CAL) && !full;
  assign last = take && (count == CNT_W'(NUM_SAMPLES - 1));
  assign sum_a_next = sum_a + SUM_W'(raw_a);
  assign sum_b_next = sum_b + SUM_W'(raw_b);

  // Sums, count, offsets and the done flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a    <= '0;
      sum_b    <= '0;
      count    <= '0;
      offset_a <= '0;
      offset_b <= '0;
      done     <= 1'b0;
    end else if (fire) begin
      if (mode == MODE_RESTART) begin
        sum_a <= '0;
        sum_b <= '0;
        count <= '0;
      end else if (take) begin
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
        count <= count + CNT_W'(1);
        if (last) begin
          // Truncated mean of the run is the top bits of the sum.
          offset_a <= sum_a_next[SUM_W-1:NUM_SAMPLES_LOG2];
          offset_b <= sum_b_next[SUM_W-1:NUM_SAMPLES_LOG2];
          done     <= 1'b1;
        end
      end
    end
  end

  assign status.offset_a  = offset_a;
  assign status.offset_b  = offset_b;
  assign status.done      = done;
  assign status.done_next = done | last;
  assign status.count     = count;

endmodule

[hw/rtl/pcoc_measure.sv]
// ----------------------------------------------------------------------------
// pcoc_measure
// Offset removal, symmetric saturation, sign inversion and phase C.
// ----------------------------------------------------------------------------
module pcoc_measure (
  input  logic                       enable,
  input  logic [pcoc_pkg::RAW_W-1:0] raw_a,
  input  logic [pcoc_pkg::RAW_W-1:0] raw_b,
  input  logic [pcoc_pkg::RAW_W-1:0] offset_a,
  input  logic [pcoc_pkg::RAW_W-1:0] offset_b,
  output pcoc_pkg::currents_t        currents
);
  import pcoc_pkg::*;

  localparam int DIFF_W = RAW_W + 1;

  // Subtract, clamp to the symmetric limit and negate.
  function automatic logic signed [CUR_W-1:0] phase_current(
    input logic [RAW_W-1:0] raw,
    input logic [RAW_W-1:0] offset
  );
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] sat;
    diff = $signed({1'b0, raw}) - $signed({1'b0, offset});
    if (diff > $signed(DIFF_W'(CUR_LIMIT))) begin
      sat = $signed(DIFF_W'(CUR_LIMIT));
    end else if (diff < -$signed(DIFF_W'(CUR_LIMIT))) begin
      sat = -$signed(DIFF_W'(CUR_LIMIT));
    end else begin
      sat = diff;
    end
    return CUR_W'(-sat);
  endfunction

  logic signed [CUR_W-1:0] cur_a;
  logic signed [CUR_W-1:0] cur_b;

  assign cur_a = phase_current(raw_a, offset_a);
  assign cur_b = phase_current(raw_b, offset_b);

  // Only measurement words carry currents; all others read as zero.
  always_comb begin
    if (enable) begin
      currents.current_a = cur_a;
      currents.current_b = cur_b;
      currents.current_c = -(CURC_W'(cur_a)) - CURC_W'(cur_b);
    end else begin
      currents = '0;
    end
  end

endmodule

[hw/rtl/phase_current_offset_calibration.sv]
// ----------------------------------------------------------------------------
// phase_current_offset_calibration
// Two-phase current sensing with converter offset calibration.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid, s_tready | tuser: mode; tdata: raw_a, raw_b
//  m_*     | out       | m_tvalid, m_tready | tdata: current_a, current_b,
//          |           |                    |        current_c, calibrated
//
//  One word per cycle sustained while m_tready is high; each word passes
//  through the input register, then the result register.
//  Synchronous reset clears sums, count, offsets and the done flag.
//  A stalled output holds its word; the input register keeps accepting
//  as long as its word can move into the result register.
// ----------------------------------------------------------------------------
module phase_current_offset_calibration (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // raw_a[15:0], raw_b[31:16]
  input  logic [pcoc_pkg::MODE_W-1:0]     s_tuser,   // mode[1:0]
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pcoc_pkg::OUT_DATA_W-1:0] m_tdata    // current_a[15:0],
                                                     // current_b[31:16],
                                                     // current_c[48:32],
                                                     // calibrated[49], zeros
);
  import pcoc_pkg::*;

  // Input register.
  logic             in_valid;
  mode_t            in_mode;
  logic [RAW_W-1:0] in_raw_a;
  logic [RAW_W-1:0] in_raw_b;

  // Result register.
  logic             out_valid;
  currents_t        out_cur;
  logic             out_cal;

  logic             advance;
  logic             s_fire;
  calib_status_t    calib_st;
  currents_t        cur;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  // Capture the incoming word.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_mode  <= mode_t'(s_tuser);
      in_raw_a <= s_tdata[RAW_W-1:0];
      in_raw_b <= s_tdata[2*RAW_W-1:RAW_W];
    end
  end

  pcoc_calib u_calib (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .mode   (in_mode),
    .raw_a  (in_raw_a),
    .raw_b  (in_raw_b),
    .status (calib_st)
  );

  pcoc_measure u_measure (
    .enable   (in_mode == MODE_MEAS),
    .raw_a    (in_raw_a),
    .raw_b    (in_raw_b),
    .offset_a (calib_st.offset_a),
    .offset_b (calib_st.offset_b),
    .currents (cur)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cur <= cur;
      out_cal <= calib_st.done_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_cal, out_cur};

`ifndef SYNTHESIS
  // The run count never goes past the run length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    calib_st.count <= CNT_W'(NUM_SAMPLES))
    else $error("calibration count exceeds run length");

  // Once calibrated, only reset clears the flag.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    calib_st.done |=> calib_st.done)
    else $error("calibration done flag dropped");

  // Phase C is always minus the sum of the other two phases.
  a_phase_c: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cur.current_c ==
                   -(CURC_W'(out_cur.current_a)) - CURC_W'(out_cur.current_b)))
    else $error("phase C mismatch");

  // A word blocked in the input register stays there.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input word lost while blocked");
`endif

endmodule
